/* hw/rtl/ldags_pkg.sv */
// ----------------------------------------------------------------------------
// ldags_pkg
// shared types and constants for the led drive auto gain stepper
// ----------------------------------------------------------------------------
package ldags_pkg;

  // field widths
  localparam int unsigned SampleW  = 24;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned GainW    = 3;
  localparam int unsigned TicksW   = 6;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUsedW = 2 * CodeW + GainW + 2;

  // apb port
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CodeW-1:0] FullScale = 8'd255;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    RegLowThreshold   = 3'd0,
    RegHighThreshold  = 3'd1,
    RegCurrentStep    = 3'd2,
    RegCurrentFloor   = 3'd3,
    RegResetGain      = 3'd4,
    RegMinGain        = 3'd5,
    RegOffPulseCurr   = 3'd6,
    RegOffPulseTicks  = 3'd7
  } reg_idx_e;

  // register reset values
  localparam logic [SampleW-1:0] LowThresholdRst  = 24'd300000;
  localparam logic [SampleW-1:0] HighThresholdRst = 24'd1000000;
  localparam logic [CodeW-1:0]   CurrentStepRst   = 8'd40;
  localparam logic [CodeW-1:0]   CurrentFloorRst  = 8'd175;
  localparam logic [GainW-1:0]   ResetGainRst     = 3'd5;
  localparam logic [GainW-1:0]   MinGainRst       = 3'd1;
  localparam logic [CodeW-1:0]   OffPulseCurrRst  = 8'd50;
  localparam logic [TicksW-1:0]  OffPulseTicksRst = 6'd2;

  // gain after reset
  localparam logic [GainW-1:0]   GainRst          = 3'd5;

  typedef struct packed {
    logic             min_reached;
    logic             light_changed;
    logic [GainW-1:0] gain_step;
    logic [CodeW-1:0] led_two_current;
    logic [CodeW-1:0] led_one_current;
  } result_t;

endpackage

/* hw/rtl/led_drive_auto_gain_stepper.sv */
// ----------------------------------------------------------------------------
// led_drive_auto_gain_stepper
// per-frame led current and front-end gain control from ambient-corrected ir
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata: ir_sample; tuser: sensor_off
//  m_axis    out  tvalid / tready        tdata: led one, led two, gain, flags
//  apb       in   psel/penable/pready    8 config registers at 4*i
//
//  one beat per cycle sustained while the result side is ready: a beat lands
//  in the input register, then the update logic (24-bit compares, one 9-bit
//  subtract) runs against the live state and writes state and the result
//  register together once the result register is empty or being taken;
//  result valid is the valid bit of the result register
//  input ready only drops when the input register is full and the result
//  register is full and not being taken this cycle
//  reset puts the current at full scale, the gain at its reset step, the
//  frame counter at zero and the config registers at their defaults
//
module led_drive_auto_gain_stepper #(
  parameter int unsigned BLINK_PERIOD = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [23:0] ir_sample
  input  logic [ldags_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] sensor_off
  input  logic                           s_axis_tuser,

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] led_one_current, [15:8] led_two_current, [18:16] gain_step,
  // [19] light_changed, [20] min_reached, [23:21] zero
  output logic [ldags_pkg::OutDataW-1:0] m_axis_tdata,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ldags_pkg::ApbAddrW-1:0] paddr,
  input  logic [ldags_pkg::ApbDataW-1:0] pwdata,
  output logic [ldags_pkg::ApbDataW-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned TickW = $clog2(BLINK_PERIOD);
  localparam logic [TickW:0] PeriodVal = (TickW + 1)'(BLINK_PERIOD);

  // config registers
  logic [ldags_pkg::SampleW-1:0] low_thr_q, high_thr_q;
  logic [ldags_pkg::CodeW-1:0]   cur_step_q, cur_floor_q, off_curr_q;
  logic [ldags_pkg::GainW-1:0]   rst_gain_q, min_gain_q;
  logic [ldags_pkg::TicksW-1:0]  off_ticks_q;

  // block state
  logic [ldags_pkg::CodeW-1:0]   drive_q, drive_d;
  logic [ldags_pkg::GainW-1:0]   gain_q, gain_d;
  logic [TickW-1:0]              tick_q, tick_d;

  // input register
  logic                          in_vld_q;
  logic [ldags_pkg::SampleW-1:0] sample_q;
  logic                          off_q;

  // result register
  logic                          out_vld_q;
  ldags_pkg::result_t            res_q, res_d;

  logic                          advance;
  logic                          cfg_wr;
  ldags_pkg::reg_idx_e           cfg_idx;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = ldags_pkg::reg_idx_e'(paddr[4:2]);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q   <= ldags_pkg::LowThresholdRst;
      high_thr_q  <= ldags_pkg::HighThresholdRst;
      cur_step_q  <= ldags_pkg::CurrentStepRst;
      cur_floor_q <= ldags_pkg::CurrentFloorRst;
      rst_gain_q  <= ldags_pkg::ResetGainRst;
      min_gain_q  <= ldags_pkg::MinGainRst;
      off_curr_q  <= ldags_pkg::OffPulseCurrRst;
      off_ticks_q <= ldags_pkg::OffPulseTicksRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ldags_pkg::RegLowThreshold:  low_thr_q   <= pwdata[ldags_pkg::SampleW-1:0];
        ldags_pkg::RegHighThreshold: high_thr_q  <= pwdata[ldags_pkg::SampleW-1:0];
        ldags_pkg::RegCurrentStep:   cur_step_q  <= pwdata[ldags_pkg::CodeW-1:0];
        ldags_pkg::RegCurrentFloor:  cur_floor_q <= pwdata[ldags_pkg::CodeW-1:0];
        ldags_pkg::RegResetGain:     rst_gain_q  <= pwdata[ldags_pkg::GainW-1:0];
        ldags_pkg::RegMinGain:       min_gain_q  <= pwdata[ldags_pkg::GainW-1:0];
        ldags_pkg::RegOffPulseCurr:  off_curr_q  <= pwdata[ldags_pkg::CodeW-1:0];
        ldags_pkg::RegOffPulseTicks: off_ticks_q <= pwdata[ldags_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      ldags_pkg::RegLowThreshold:  prdata = ldags_pkg::ApbDataW'(low_thr_q);
      ldags_pkg::RegHighThreshold: prdata = ldags_pkg::ApbDataW'(high_thr_q);
      ldags_pkg::RegCurrentStep:   prdata = ldags_pkg::ApbDataW'(cur_step_q);
      ldags_pkg::RegCurrentFloor:  prdata = ldags_pkg::ApbDataW'(cur_floor_q);
      ldags_pkg::RegResetGain:     prdata = ldags_pkg::ApbDataW'(rst_gain_q);
      ldags_pkg::RegMinGain:       prdata = ldags_pkg::ApbDataW'(min_gain_q);
      ldags_pkg::RegOffPulseCurr:  prdata = ldags_pkg::ApbDataW'(off_curr_q);
      ldags_pkg::RegOffPulseTicks: prdata = ldags_pkg::ApbDataW'(off_ticks_q);
      default:                     prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata[ldags_pkg::SampleW-1:0];
      off_q    <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------- update logic
  logic [TickW:0]               tick_inc;
  logic                         weak_hit, strong_hit;
  logic [ldags_pkg::CodeW:0]    diff;
  logic                         below_floor;
  logic [ldags_pkg::GainW:0]    min_plus1;
  logic                         clamp;
  logic                         changed, at_min;
  logic [ldags_pkg::CodeW-1:0]  led_two;

  always_comb begin
    // frame counter wraps at the blink period, blink test uses the new value
    tick_inc = {1'b0, tick_q} + 1'b1;
    tick_d   = (tick_inc >= PeriodVal) ? '0 : tick_inc[TickW-1:0];

    weak_hit   = (sample_q < low_thr_q) && (gain_q <= min_gain_q);
    strong_hit = (sample_q >= high_thr_q);

    // borrow means the step exceeds the current, treated as below floor
    diff        = {1'b0, drive_q} - {1'b0, cur_step_q};
    below_floor = diff[ldags_pkg::CodeW] || (diff[ldags_pkg::CodeW-1:0] < cur_floor_q);

    // gain - 1 <= min, with gain of zero going negative
    min_plus1 = {1'b0, min_gain_q} + 1'b1;
    clamp     = ({1'b0, gain_q} <= min_plus1);

    drive_d = drive_q;
    gain_d  = gain_q;
    changed = 1'b0;
    at_min  = 1'b0;

    if (weak_hit) begin
      drive_d = ldags_pkg::FullScale;
      gain_d  = rst_gain_q;
      changed = 1'b1;
    end else if (strong_hit) begin
      changed = 1'b1;
      if (below_floor) begin
        drive_d = ldags_pkg::FullScale;
        if (clamp) begin
          gain_d = min_gain_q;
          at_min = 1'b1;
        end else begin
          gain_d = gain_q - 1'b1;
        end
      end else begin
        drive_d = diff[ldags_pkg::CodeW-1:0];
      end
    end

    // second led blinks while the probe is off
    if (off_q) begin
      led_two = (ldags_pkg::TicksW'(tick_d) < off_ticks_q) ? off_curr_q : '0;
    end else begin
      led_two = drive_d;
    end

    res_d.led_one_current = drive_d;
    res_d.led_two_current = led_two;
    res_d.gain_step       = gain_d;
    res_d.light_changed   = changed;
    res_d.min_reached     = at_min;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= ldags_pkg::FullScale;
      gain_q  <= ldags_pkg::GainRst;
      tick_q  <= '0;
    end else if (advance) begin
      drive_q <= drive_d;
      gain_q  <= gain_d;
      tick_q  <= tick_d;
    end
  end

  // ---------------------------------------------------------- result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(ldags_pkg::OutDataW - ldags_pkg::OutUsedW){1'b0}}, res_q};

endmodule

/* sim/ldags_checker.sv */
// ----------------------------------------------------------------------------
// ldags_checker
// watches the apb port and both streams of the led drive auto gain stepper,
// tracks the drive/gain/frame state per input beat and compares every result
// beat field by field against the oldest predicted drive setting
// ----------------------------------------------------------------------------
module ldags_checker #(
  parameter int unsigned BLINK_PERIOD = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // [23:0] ir_sample
  input  logic [ldags_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] sensor_off
  input  logic                           s_axis_tuser,

  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] led_one_current, [15:8] led_two_current, [18:16] gain_step,
  // [19] light_changed, [20] min_reached, [23:21] zero
  input  logic [ldags_pkg::OutDataW-1:0] m_axis_tdata,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [ldags_pkg::ApbAddrW-1:0] paddr,
  input  logic [ldags_pkg::ApbDataW-1:0] pwdata,

  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [ldags_pkg::SampleW-1:0] low_thr;
  logic [ldags_pkg::SampleW-1:0] high_thr;
  logic [ldags_pkg::CodeW-1:0]   step_size;
  logic [ldags_pkg::CodeW-1:0]   floor_code;
  logic [ldags_pkg::GainW-1:0]   restore_gain;
  logic [ldags_pkg::GainW-1:0]   gain_floor;
  logic [ldags_pkg::CodeW-1:0]   pulse_code;
  logic [ldags_pkg::TicksW-1:0]  pulse_ticks;

  // tracked block state
  logic [ldags_pkg::CodeW-1:0]   led_code;
  logic [ldags_pkg::GainW-1:0]   gain_sel;
  logic [ldags_pkg::TicksW-1:0]  tick_cnt;

  ldags_pkg::result_t            drive_q[$];
  int unsigned                   fails;

  // one frame of the control loop, returns the drive setting it leaves
  function automatic ldags_pkg::result_t advance_frame(
    logic [ldags_pkg::SampleW-1:0] sample, logic off);
    ldags_pkg::result_t r;
    int                 dec_gain;
    r = '0;
    tick_cnt = tick_cnt + 1'b1;
    if (int'(tick_cnt) >= int'(BLINK_PERIOD)) tick_cnt = '0;
    if (sample < low_thr && gain_sel <= gain_floor) begin
      // weak signal at minimum gain wins over the strong test
      led_code = ldags_pkg::FullScale;
      gain_sel = restore_gain;
      r.light_changed = 1'b1;
    end else if (sample >= high_thr) begin
      r.light_changed = 1'b1;
      if (step_size > led_code || led_code - step_size < floor_code) begin
        dec_gain = int'(gain_sel) - 1;
        led_code = ldags_pkg::FullScale;
        if (dec_gain <= int'(gain_floor)) begin
          gain_sel = gain_floor;
          r.min_reached = 1'b1;
        end else begin
          gain_sel = ldags_pkg::GainW'(dec_gain);
        end
      end else begin
        led_code = led_code - step_size;
      end
    end
    r.led_one_current = led_code;
    if (!off) r.led_two_current = led_code;
    else r.led_two_current = (tick_cnt < pulse_ticks) ? pulse_code : '0;
    r.gain_step = gain_sel;
    return r;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns  %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ldags_pkg::result_t want;
    ldags_pkg::result_t got;
    if (!rst_ni) begin
      low_thr      = ldags_pkg::LowThresholdRst;
      high_thr     = ldags_pkg::HighThresholdRst;
      step_size    = ldags_pkg::CurrentStepRst;
      floor_code   = ldags_pkg::CurrentFloorRst;
      restore_gain = ldags_pkg::ResetGainRst;
      gain_floor   = ldags_pkg::MinGainRst;
      pulse_code   = ldags_pkg::OffPulseCurrRst;
      pulse_ticks  = ldags_pkg::OffPulseTicksRst;
      led_code     = ldags_pkg::FullScale;
      gain_sel     = ldags_pkg::GainRst;
      tick_cnt     = '0;
      drive_q.delete();
      fails        = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ldags_pkg::reg_idx_e'(paddr[4:2]))
          ldags_pkg::RegLowThreshold:  low_thr      = pwdata[ldags_pkg::SampleW-1:0];
          ldags_pkg::RegHighThreshold: high_thr     = pwdata[ldags_pkg::SampleW-1:0];
          ldags_pkg::RegCurrentStep:   step_size    = pwdata[ldags_pkg::CodeW-1:0];
          ldags_pkg::RegCurrentFloor:  floor_code   = pwdata[ldags_pkg::CodeW-1:0];
          ldags_pkg::RegResetGain:     restore_gain = pwdata[ldags_pkg::GainW-1:0];
          ldags_pkg::RegMinGain:       gain_floor   = pwdata[ldags_pkg::GainW-1:0];
          ldags_pkg::RegOffPulseCurr:  pulse_code   = pwdata[ldags_pkg::CodeW-1:0];
          ldags_pkg::RegOffPulseTicks: pulse_ticks  = pwdata[ldags_pkg::TicksW-1:0];
          default: ;
        endcase
      end
      // a result beat always belongs to an older input, so check before pushing
      if (m_axis_tvalid && m_axis_tready) begin
        got = ldags_pkg::result_t'(m_axis_tdata[ldags_pkg::OutUsedW-1:0]);
        if (drive_q.size() == 0) begin
          $display("%0t ns  result beat with nothing expected: expected none, got %h",
                   $time, m_axis_tdata);
          fails++;
        end else begin
          want = drive_q.pop_front();
          compare_field("led_one_current", 32'(want.led_one_current),
                        32'(got.led_one_current));
          compare_field("led_two_current", 32'(want.led_two_current),
                        32'(got.led_two_current));
          compare_field("gain_step", 32'(want.gain_step), 32'(got.gain_step));
          compare_field("light_changed", 32'(want.light_changed), 32'(got.light_changed));
          compare_field("min_reached", 32'(want.min_reached), 32'(got.min_reached));
          compare_field("tdata padding", 32'd0,
                        32'(m_axis_tdata[ldags_pkg::OutDataW-1:ldags_pkg::OutUsedW]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        drive_q.push_back(advance_frame(s_axis_tdata[ldags_pkg::SampleW-1:0], s_axis_tuser));
    end
    pending_o    <= drive_q.size();
    fail_count_o <= fails;
  end

endmodule

/* sim/tb_led_drive_auto_gain_stepper.sv */
// ----------------------------------------------------------------------------
// tb_led_drive_auto_gain_stepper
// drives ir samples through the led drive auto gain stepper under several
// register settings and idle/stall mixes; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_led_drive_auto_gain_stepper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BlinkPeriod   = 20;
  // covers the pass through the input and result registers, plus margin
  localparam int unsigned SettleCycles  = 8;
  // cycles without any beat or apb access before the run is called hung
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned BeatsPerPhase = 150;

  logic                            clk_i;
  logic                            rst_ni        = 1'b0;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [23:0] ir_sample
  logic [ldags_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  // [0] sensor_off
  logic                            s_axis_tuser  = 1'b0;

  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [7:0] led_one_current, [15:8] led_two_current, [18:16] gain_step,
  // [19] light_changed, [20] min_reached, [23:21] zero
  logic [ldags_pkg::OutDataW-1:0]  m_axis_tdata;

  logic                            psel          = 1'b0;
  logic                            penable       = 1'b0;
  logic                            pwrite        = 1'b0;
  logic [ldags_pkg::ApbAddrW-1:0]  paddr         = '0;
  logic [ldags_pkg::ApbDataW-1:0]  pwdata        = '0;
  logic [ldags_pkg::ApbDataW-1:0]  prdata;
  logic                            pready;

  int unsigned                     pending;
  int unsigned                     fail_count;
  int unsigned                     quiet_cycles  = 0;

  // percent chance per cycle that the sender idles / the receiver stalls
  int unsigned                     idle_pct      = 0;
  int unsigned                     stall_pct     = 0;

  led_drive_auto_gain_stepper #(
    .BLINK_PERIOD (BlinkPeriod)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  ldags_checker #(
    .BLINK_PERIOD (BlinkPeriod)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .pready,
    .paddr,
    .pwdata,
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side backpressure, reshuffled every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // hang detector: any beat or apb access counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one register write: setup cycle, then access cycle; psel stays up for
  // back-to-back writes and is dropped by the caller
  task automatic apb_write(input ldags_pkg::reg_idx_e idx,
                           input logic [ldags_pkg::ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  // one input beat with random idle cycles ahead of it; tready is sampled at
  // the falling edge, where it already holds its value for the next rising edge
  task automatic send_beat(input logic [ldags_pkg::SampleW-1:0] sample, input logic off);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tuser  <= off;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // hold off until every predicted drive setting has come back, then let the
  // pipeline settle; returns on a rising edge
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [ldags_pkg::ApbDataW-1:0] setting [8];
    logic [ldags_pkg::SampleW-1:0]  low_thr;
    logic [ldags_pkg::SampleW-1:0]  high_thr;
    logic [ldags_pkg::SampleW-1:0]  sample;
    logic [ldags_pkg::SampleW-1:0]  a;
    logic [ldags_pkg::SampleW-1:0]  b;
    logic                           off_flag;
    int unsigned                    pick;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk at the reset settings
    low_thr  = ldags_pkg::LowThresholdRst;
    high_thr = ldags_pkg::HighThresholdRst;
    // zero sample while gain is above minimum: nothing changes
    send_beat('0, 1'b0);
    // just under the high threshold: between thresholds
    send_beat(high_thr - 1'b1, 1'b0);
    // exactly at the high threshold counts as strong
    send_beat(high_thr, 1'b0);
    // full scale samples walk the current down past the floor four times,
    // stepping the gain down until it clamps at minimum
    repeat (11) send_beat('1, 1'b0);
    // weak sample at minimum gain restores drive, sensor off from here
    send_beat(low_thr - 1'b1, 1'b1);
    // exactly at the low threshold is not weak
    send_beat(low_thr, 1'b1);
    // carry the frame counter through its wrap while the second led blinks
    repeat (6) send_beat(24'd500000, 1'b1);
    // alternating bit patterns on the sample
    send_beat(24'h555555, 1'b0);
    send_beat(24'hAAAAAA, 1'b1);

    off_flag = 1'b0;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      // sender pauses until everything is back before touching registers
      s_axis_tvalid <= 1'b0;
      wait_drained();

      case (phase)
        0: setting = '{ldags_pkg::ApbDataW'(ldags_pkg::LowThresholdRst),
                       ldags_pkg::ApbDataW'(ldags_pkg::HighThresholdRst),
                       ldags_pkg::ApbDataW'(ldags_pkg::CurrentStepRst),
                       ldags_pkg::ApbDataW'(ldags_pkg::CurrentFloorRst),
                       ldags_pkg::ApbDataW'(ldags_pkg::ResetGainRst),
                       ldags_pkg::ApbDataW'(ldags_pkg::MinGainRst),
                       ldags_pkg::ApbDataW'(ldags_pkg::OffPulseCurrRst),
                       ldags_pkg::ApbDataW'(ldags_pkg::OffPulseTicksRst)};
        // low extremes: every sample is strong, gain can bottom out at zero
        1: setting = '{32'h0, 32'h0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0};
        // high extremes: step at full scale, min gain at the top
        2: setting = '{32'hFFFFFF, 32'hFFFFFF, 32'd255, 32'd255, 32'd7, 32'd7, 32'd255, 32'd63};
        // low threshold above high threshold: weak test has to win
        3: setting = '{32'h800000, 32'h400000, 32'd200, 32'd100, 32'd7, 32'd0, 32'hAA, 32'd25};
        default: begin
          a = ldags_pkg::SampleW'($urandom);
          b = ldags_pkg::SampleW'($urandom);
          // mostly ordered thresholds, sometimes crossed
          if ($urandom_range(3) != 0) begin
            setting[0] = 32'((a < b) ? a : b);
            setting[1] = 32'((a < b) ? b : a);
          end else begin
            setting[0] = 32'((a < b) ? b : a);
            setting[1] = 32'((a < b) ? a : b);
          end
          setting[2] = $urandom_range(255, 1);
          setting[3] = $urandom_range(255, 0);
          setting[4] = $urandom_range(7, 1);
          setting[5] = $urandom_range(7, 0);
          setting[6] = $urandom_range(255, 0);
          setting[7] = $urandom_range(63, 0);
        end
      endcase
      for (int r = 0; r < 8; r++) apb_write(ldags_pkg::reg_idx_e'(r), setting[r]);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      low_thr  = setting[0][ldags_pkg::SampleW-1:0];
      high_thr = setting[1][ldags_pkg::SampleW-1:0];

      // idle mix: none, sender idle, receiver stall, both
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 57; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 57; end
        default: begin idle_pct = 20; stall_pct <= 20; end
      endcase

      for (int n = 0; n < BeatsPerPhase; n++) begin
        // bias toward strong samples so the gain reaches its minimum and the
        // weak restore path gets exercised
        pick = $urandom_range(99);
        if (pick < 45) begin
          sample = ldags_pkg::SampleW'($urandom_range(32'hFFFFFF, 32'(high_thr)));
        end else if (pick < 70 && low_thr != 0) begin
          sample = ldags_pkg::SampleW'($urandom_range(32'(low_thr) - 1, 0));
        end else if (pick < 80) begin
          case ($urandom_range(3))
            0: sample = low_thr - 1'b1;
            1: sample = low_thr;
            2: sample = high_thr - 1'b1;
            default: sample = high_thr;
          endcase
        end else begin
          sample = ldags_pkg::SampleW'($urandom);
        end
        // sensor off comes in runs so the blink pattern plays out
        if ($urandom_range(99) < 6) off_flag = ~off_flag;
        send_beat(sample, off_flag);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ldags_pkg.sv
hw/rtl/led_drive_auto_gain_stepper.sv
sim/ldags_checker.sv
sim/tb_led_drive_auto_gain_stepper.sv
